// ===== src/sktl_pkg.sv =====
// shared types, constants and command codes for the security key trace log device
// no dependencies; used by every module of the block but sktl_ram
package sktl_pkg;

    // log geometry; LOG_DEPTH must be a power of two
    localparam int unsigned LOG_DEPTH    = 8192;
    localparam int unsigned RECORD_WORDS = 15;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned LOG_AW    = $clog2(LOG_DEPTH);
    localparam int unsigned ROW_W     = RECORD_WORDS * WORD_W;
    localparam int unsigned STAGE_W   = $clog2(RECORD_WORDS + 2);
    localparam int unsigned STG_IDX_W = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;
    localparam int unsigned WIDX_W    = 4;
    localparam int unsigned OP_W      = 4;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 72;

    localparam logic [WORD_W-1:0] NEARFULL_RESET = 32'h0001_0200;
    localparam logic [WORD_W-1:0] LIMIT_RESET    = 32'd1024;
    localparam logic [WORD_W-1:0] GEOM_NVRAMS    = 32'd10;
    localparam logic [WORD_W-1:0] GEOM_ADDRS     = 32'd4096;

    typedef logic [RECORD_WORDS-1:0][WORD_W-1:0] row_t;

    typedef enum logic [OP_W-1:0] {
        OP_PING         = 4'd0,
        OP_ERASE        = 4'd1,
        OP_ADD_COUNT    = 4'd2,
        OP_GET_NEARFULL = 4'd3,
        OP_GET_FREE     = 4'd4,
        OP_GEOMETRY     = 4'd5,
        OP_GET_COUNT    = 4'd6,
        OP_GET_LIMIT    = 4'd7,
        OP_READ_WORD    = 4'd8,
        OP_LOG_STATE    = 4'd9,
        OP_PUT_NEARFULL = 4'd10,
        OP_PUT_LIMIT    = 4'd11,
        OP_RECORD_WORD  = 4'd12
    } op_e;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ERASE,
        CMD_ADD_COUNT,
        CMD_GET_NEARFULL,
        CMD_GET_FREE,
        CMD_GEOMETRY,
        CMD_GET_COUNT,
        CMD_GET_LIMIT,
        CMD_READ_WORD,
        CMD_LOG_STATE,
        CMD_PUT_NEARFULL,
        CMD_PUT_LIMIT,
        CMD_RECORD_WORD
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LENGTH  = 2'd1,
        ST_FULL    = 2'd2,
        ST_AT_HEAD = 2'd3
    } status_e;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_e;

    typedef struct packed {
        cmd_e               kind;
        logic [WORD_W-1:0]  value;
        logic [WIDX_W-1:0]  widx;
        logic               widx_ok;
        logic               last;
    } cmd_t;

endpackage

// ===== src/sktl_ram.sv =====
// generic single-port ram with registered read data
// no dependencies
module sktl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata <= mem_reg[addr];
            end
        end
    end

endmodule

// ===== src/sktl_front.sv =====
// front end: accepts command beats and decodes them into queue entries
// depends on sktl_pkg
module sktl_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sktl_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // value, word_index
    input  logic [sktl_pkg::OP_W-1:0]       s_axis_tuser,  // op
    input  logic                            s_axis_tlast,
    output logic                            push,
    output sktl_pkg::cmd_t                  push_cmd,
    input  logic                            q_full
);

    logic           fr_valid_reg;
    logic           fr_valid_next;
    sktl_pkg::cmd_t fr_cmd_reg;
    sktl_pkg::cmd_t dec_cmd;
    logic           accept;

    assign s_axis_tready = !fr_valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = fr_valid_reg && !q_full;
    assign push_cmd      = fr_cmd_reg;

    always_comb
    begin
        dec_cmd.value   = s_axis_tdata[sktl_pkg::WORD_W-1:0];
        dec_cmd.widx    = s_axis_tdata[sktl_pkg::WORD_W +: sktl_pkg::WIDX_W];
        dec_cmd.widx_ok = {1'b0, dec_cmd.widx} < 5'(sktl_pkg::RECORD_WORDS);
        dec_cmd.last    = s_axis_tlast;
        case (sktl_pkg::op_e'(s_axis_tuser))
            sktl_pkg::OP_ERASE:        dec_cmd.kind = sktl_pkg::CMD_ERASE;
            sktl_pkg::OP_ADD_COUNT:    dec_cmd.kind = sktl_pkg::CMD_ADD_COUNT;
            sktl_pkg::OP_GET_NEARFULL: dec_cmd.kind = sktl_pkg::CMD_GET_NEARFULL;
            sktl_pkg::OP_GET_FREE:     dec_cmd.kind = sktl_pkg::CMD_GET_FREE;
            sktl_pkg::OP_GEOMETRY:     dec_cmd.kind = sktl_pkg::CMD_GEOMETRY;
            sktl_pkg::OP_GET_COUNT:    dec_cmd.kind = sktl_pkg::CMD_GET_COUNT;
            sktl_pkg::OP_GET_LIMIT:    dec_cmd.kind = sktl_pkg::CMD_GET_LIMIT;
            sktl_pkg::OP_READ_WORD:    dec_cmd.kind = sktl_pkg::CMD_READ_WORD;
            sktl_pkg::OP_LOG_STATE:    dec_cmd.kind = sktl_pkg::CMD_LOG_STATE;
            sktl_pkg::OP_PUT_NEARFULL: dec_cmd.kind = sktl_pkg::CMD_PUT_NEARFULL;
            sktl_pkg::OP_PUT_LIMIT:    dec_cmd.kind = sktl_pkg::CMD_PUT_LIMIT;
            sktl_pkg::OP_RECORD_WORD:  dec_cmd.kind = sktl_pkg::CMD_RECORD_WORD;
            default:                   dec_cmd.kind = sktl_pkg::CMD_NONE;
        endcase
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fr_cmd_reg <= dec_cmd;
        end
    end

endmodule

// ===== src/sktl_queue.sv =====
// two-entry command queue between front and back end
// depends on sktl_pkg
module sktl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sktl_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output sktl_pkg::cmd_t q_cmd
);

    sktl_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/sktl_back.sv =====
// back end: executes commands against counters, staging buffer and log memory
// depends on sktl_pkg and sktl_ram
module sktl_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  sktl_pkg::cmd_t                   q_cmd,
    output logic                             pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sktl_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // status, word_a, word_b
);

    localparam int unsigned W = sktl_pkg::WORD_W;

    sktl_pkg::back_state_e state_reg;
    sktl_pkg::back_state_e state_next;
    logic                  exec_fire;

    sktl_pkg::cmd_t        cur_cmd_reg;

    logic [W-1:0] head_reg;
    logic [W-1:0] head_next;
    logic [W-1:0] tail_reg;
    logic [W-1:0] tail_next;
    logic [W-1:0] count_reg;
    logic [W-1:0] count_next;
    logic [W-1:0] limit_reg;
    logic [W-1:0] limit_next;
    logic [W-1:0] nearfull_reg;
    logic [W-1:0] nearfull_next;
    logic [sktl_pkg::STAGE_W-1:0] staged_reg;
    logic [sktl_pkg::STAGE_W-1:0] staged_next;
    sktl_pkg::row_t staging_reg;

    logic           out_valid_reg;
    logic           out_valid_next;
    logic [1:0]     status_reg;
    logic [W-1:0]   word_a_reg;
    logic [W-1:0]   word_b_reg;

    sktl_pkg::status_e res_status;
    logic [W-1:0]   res_a;
    logic [W-1:0]   res_b;
    logic [W-1:0]   used;
    logic           stage_room;
    logic [sktl_pkg::STAGE_W-1:0] staged_inc;
    logic           commit;
    sktl_pkg::row_t commit_row;
    sktl_pkg::row_t rd_row;

    logic                        ram_en;
    logic                        ram_we;
    logic [sktl_pkg::LOG_AW-1:0] ram_addr;
    logic [sktl_pkg::ROW_W-1:0]  ram_rdata;

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sktl_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = sktl_pkg::BK_EXEC;
                end
            end
            sktl_pkg::BK_EXEC:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = sktl_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sktl_pkg::BK_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        pop       = 1'b0;
        exec_fire = 1'b0;
        case (state_reg)
            sktl_pkg::BK_IDLE: pop       = q_valid;
            sktl_pkg::BK_EXEC: exec_fire = !out_valid_reg || m_axis_tready;
            default:
            begin
                pop       = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    // row fetch on pop, row write on commit
    assign ram_en   = pop || commit;
    assign ram_we   = commit;
    assign ram_addr = commit ? head_reg[sktl_pkg::LOG_AW-1:0]
                             : q_cmd.value[sktl_pkg::LOG_AW-1:0];
    assign rd_row   = sktl_pkg::row_t'(ram_rdata);

    sktl_ram #(
        .WIDTH (sktl_pkg::ROW_W),
        .DEPTH (sktl_pkg::LOG_DEPTH)
    ) u_log_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (commit_row),
        .rdata (ram_rdata)
    );

    // command execution
    always_comb
    begin
        used          = head_reg - tail_reg;
        stage_room    = staged_reg < sktl_pkg::STAGE_W'(sktl_pkg::RECORD_WORDS);
        staged_inc    = (staged_reg <= sktl_pkg::STAGE_W'(sktl_pkg::RECORD_WORDS))
                        ? staged_reg + 1'b1 : staged_reg;
        commit_row    = staging_reg;
        commit_row[sktl_pkg::RECORD_WORDS-1] = cur_cmd_reg.value;
        commit        = 1'b0;
        res_status    = sktl_pkg::ST_OK;
        res_a         = '0;
        res_b         = '0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        limit_next    = limit_reg;
        nearfull_next = nearfull_reg;
        staged_next   = staged_reg;
        case (cur_cmd_reg.kind)
            sktl_pkg::CMD_ERASE:
            begin
                tail_next = tail_reg + ((cur_cmd_reg.value < used) ? cur_cmd_reg.value : used);
            end
            sktl_pkg::CMD_ADD_COUNT:
            begin
                count_next = count_reg + cur_cmd_reg.value;
                res_a      = count_next;
            end
            sktl_pkg::CMD_GET_NEARFULL: res_a = nearfull_reg;
            sktl_pkg::CMD_GET_FREE:     res_a = W'(sktl_pkg::LOG_DEPTH) - used;
            sktl_pkg::CMD_GEOMETRY:
            begin
                res_a = sktl_pkg::GEOM_NVRAMS;
                res_b = sktl_pkg::GEOM_ADDRS;
            end
            sktl_pkg::CMD_GET_COUNT:    res_a = count_reg;
            sktl_pkg::CMD_GET_LIMIT:    res_a = limit_reg;
            sktl_pkg::CMD_READ_WORD:
            begin
                if (cur_cmd_reg.value == head_reg)
                begin
                    res_status = sktl_pkg::ST_AT_HEAD;
                end
                else if (cur_cmd_reg.widx_ok)
                begin
                    res_a = rd_row[cur_cmd_reg.widx[sktl_pkg::STG_IDX_W-1:0]];
                end
            end
            sktl_pkg::CMD_LOG_STATE:
            begin
                res_a = used;
                res_b = tail_reg;
            end
            sktl_pkg::CMD_PUT_NEARFULL: nearfull_next = cur_cmd_reg.value;
            sktl_pkg::CMD_PUT_LIMIT:    limit_next    = cur_cmd_reg.value;
            sktl_pkg::CMD_RECORD_WORD:
            begin
                if (!cur_cmd_reg.last)
                begin
                    staged_next = staged_inc;
                end
                else
                begin
                    staged_next = '0;
                    if (staged_inc != sktl_pkg::STAGE_W'(sktl_pkg::RECORD_WORDS))
                    begin
                        res_status = sktl_pkg::ST_LENGTH;
                    end
                    else if (used >= W'(sktl_pkg::LOG_DEPTH))
                    begin
                        res_status = sktl_pkg::ST_FULL;
                    end
                    else
                    begin
                        commit    = exec_fire;
                        head_next = head_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                res_status = sktl_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sktl_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= sktl_pkg::LIMIT_RESET;
            nearfull_reg  <= sktl_pkg::NEARFULL_RESET;
            staged_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_fire)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                count_reg    <= count_next;
                limit_reg    <= limit_next;
                nearfull_reg <= nearfull_next;
                staged_reg   <= staged_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_cmd_reg <= q_cmd;
        end
        if (exec_fire)
        begin
            status_reg <= res_status;
            word_a_reg <= res_a;
            word_b_reg <= res_b;
            if (cur_cmd_reg.kind == sktl_pkg::CMD_RECORD_WORD && stage_room)
            begin
                staging_reg[staged_reg[sktl_pkg::STG_IDX_W-1:0]] <= cur_cmd_reg.value;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, word_b_reg, word_a_reg, status_reg};

endmodule

// ===== src/security_key_trace_log_device.sv =====
// security key trace log device: play counter, stored words and a ring log of records
// path from input beat to result beat: front register, queue, row fetch, execute
// the back end takes a new command only after it has fetched and executed the last one's log row
// the log memory has a single port, one full record row wide
// reset: asynchronous, clears counters, pointers, staging count and queues; log memory is not cleared
// depends on sktl_pkg, sktl_front, sktl_queue, sktl_back
module security_key_trace_log_device (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sktl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value, word_index
    input  logic [sktl_pkg::OP_W-1:0]        s_axis_tuser,  // op
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sktl_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // status, word_a, word_b
);

    logic           push;
    sktl_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    sktl_pkg::cmd_t q_cmd;

    sktl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full)
    );

    sktl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    sktl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
